// ----- src/ymodem_block_deframer_assert.svh -----
// assertion macros shared by the deframer
`ifndef YMODEM_BLOCK_DEFRAMER_ASSERT_SVH
`define YMODEM_BLOCK_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define YMBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ymbd check failed");

// next-cycle implication, checked outside reset
`define YMBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ymbd check failed");

`endif

// ----- src/ymbd_pkg.sv -----
package ymbd_pkg;

    // block lengths in payload bytes
    localparam int SHORT_LEN = 128;
    localparam int LONG_LEN  = 1024;
    localparam int CNT_W     = $clog2(LONG_LEN + 1);
    localparam int OFF_W     = 10;

    // framing bytes
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_EOT = 8'h04;

    // crc-16 constants
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    typedef enum logic [2:0] {
        EV_BUSY     = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_GOOD     = 3'd2,
        EV_EOT      = 3'd3,
        EV_BADSTART = 3'd4,
        EV_NUMBAD   = 3'd5,
        EV_CRCBAD   = 3'd6
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic [7:0]         payload_byte;
        logic [OFF_W-1:0]   payload_offset;
        logic [7:0]         block_number;
        logic               long_block;
    } t_result;

endpackage

// ----- src/ymodem_block_deframer.sv -----
// YMODEM block deframer with CRC-16 check.
// Input channel: one received serial byte per transfer on i_rx_byte,
// handshake i_in_valid / o_in_ready. Output channel: exactly one result
// per input byte (event code, payload byte and offset, block number,
// long-block flag), handshake o_out_valid / i_out_ready.
// A result is registered and presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; the framing
// state and the byte-wide crc update are combinational, ahead of the result register.
// Stall: while a result waits and i_out_ready is low, o_in_ready is low;
// it is high whenever the result register is empty or drains this cycle.
// Reset (i_rst_n low, synchronous): back to hunting for a start byte,
// block number, length flag, counters and crc cleared, result discarded.
// Bytes after a start byte are taken as block data with no resync until
// the trailing crc; a bad block-number complement returns to hunting.
module ymodem_block_deframer
    import ymbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_rx_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_payload_byte,
    output logic [OFF_W-1:0] o_payload_offset,
    output logic [7:0]       o_block_number,
    output logic             o_long_block
);

`include "ymodem_block_deframer_assert.svh"

    logic    in_xfer;
    logic    slot_free;
    t_result step_res;
    t_result out_res;

    assign o_in_ready = slot_free;
    assign in_xfer    = i_in_valid && slot_free;

    // framing state machine and crc
    ymbd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (in_xfer),
        .i_rx_byte (i_rx_byte),
        .o_result  (step_res)
    );

    // result register toward the receiver
    ymbd_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_xfer),
        .i_result    (step_res),
        .i_out_ready (i_out_ready),
        .o_free      (slot_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_res)
    );

    assign o_event_res      = out_res.event_res;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_payload_offset = out_res.payload_offset;
    assign o_block_number   = out_res.block_number;
    assign o_long_block     = out_res.long_block;

    // every accepted byte yields a result in the next cycle
    `YMBD_ASSERT_NEXT(a_xfer_gives_result, i_clk, i_rst_n, in_xfer, o_out_valid)

    // offset stays within the block length
    `YMBD_ASSERT_NOW(a_offset_in_block, i_clk, i_rst_n,
        o_out_valid && o_event_res == EV_PAYLOAD,
        (o_long_block ? (32'(o_payload_offset) < LONG_LEN)
                      : (32'(o_payload_offset) < SHORT_LEN)))

    // payload fields are zero outside payload events
    `YMBD_ASSERT_NOW(a_payload_zero, i_clk, i_rst_n,
        o_out_valid && o_event_res != EV_PAYLOAD,
        o_payload_byte == 8'h00 && o_payload_offset == '0)

endmodule

// ----- src/ymbd_crc16.sv -----
module ymbd_crc16
    import ymbd_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    // one byte of msb-first crc-16, eight shift steps
    always_comb begin
        logic [15:0] v;
        v = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_TOP) != 16'h0000) begin
                v = (v << 1) ^ CRC_POLY;
            end else begin
                v = v << 1;
            end
        end
        o_crc = v;
    end

endmodule

// ----- src/ymbd_ctrl.sv -----
module ymbd_ctrl
    import ymbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    output t_result    o_result
);

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_NUM  = 6'b000010,
        PH_NUMC = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CRCH = 6'b010000,
        PH_CRCL = 6'b100000
    } t_phase;

    t_phase             r_phase,     n_phase;
    logic               r_is_long,   n_is_long;
    logic [7:0]         r_seq,       n_seq;
    logic [CNT_W-1:0]   r_count,     n_count;
    logic [15:0]        r_crc,       n_crc;
    logic [7:0]         r_crc_high,  n_crc_high;
    logic [15:0]        crc_upd;
    logic [CNT_W-1:0]   blk_len;

    ymbd_crc16 u_crc (
        .i_crc  (r_crc),
        .i_data (i_rx_byte),
        .o_crc  (crc_upd)
    );

    assign blk_len = r_is_long ? CNT_W'(LONG_LEN) : CNT_W'(SHORT_LEN);

    // next state and result for the byte on the input
    always_comb begin
        n_phase    = r_phase;
        n_is_long  = r_is_long;
        n_seq      = r_seq;
        n_count    = r_count;
        n_crc      = r_crc;
        n_crc_high = r_crc_high;
        o_result.event_res      = EV_BUSY;
        o_result.payload_byte   = 8'h00;
        o_result.payload_offset = '0;
        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte inside {BYTE_SOH, BYTE_STX}) begin
                    n_is_long = (i_rx_byte == BYTE_STX);
                    n_phase   = PH_NUM;
                end else if (i_rx_byte == BYTE_EOT) begin
                    o_result.event_res = EV_EOT;
                end else begin
                    o_result.event_res = EV_BADSTART;
                end
            end
            PH_NUM: begin
                n_seq   = i_rx_byte;
                n_phase = PH_NUMC;
            end
            PH_NUMC: begin
                if (~i_rx_byte == r_seq) begin
                    n_phase = PH_DATA;
                    n_count = '0;
                    n_crc   = 16'h0000;
                end else begin
                    o_result.event_res = EV_NUMBAD;
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                o_result.event_res      = EV_PAYLOAD;
                o_result.payload_byte   = i_rx_byte;
                o_result.payload_offset = OFF_W'(r_count);
                n_crc   = crc_upd;
                n_count = r_count + 1'b1;
                if (n_count >= blk_len) begin
                    n_phase = PH_CRCH;
                end
            end
            PH_CRCH: begin
                n_crc_high = i_rx_byte;
                n_phase    = PH_CRCL;
            end
            PH_CRCL: begin
                o_result.event_res = ({r_crc_high, i_rx_byte} == r_crc) ? EV_GOOD : EV_CRCBAD;
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        o_result.block_number = n_seq;
        o_result.long_block   = n_is_long;
    end

    // framing state, advanced once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_is_long  <= 1'b0;
            r_seq      <= 8'h00;
            r_count    <= '0;
            r_crc      <= 16'h0000;
            r_crc_high <= 8'h00;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_is_long  <= n_is_long;
            r_seq      <= n_seq;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_crc_high <= n_crc_high;
        end
    end

endmodule

// ----- src/ymbd_out_reg.sv -----
module ymbd_out_reg
    import ymbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_free,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // slot is free when empty or drained in this cycle
    assign o_free  = !r_valid || i_out_ready;
    assign n_valid = i_load || (r_valid && !i_out_ready);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule
